/* sv/swrm_pkg.sv */
// Shared types, constants and helpers of the sliding-window rate meter.
`timescale 1ns / 1ps
package swrm_pkg;

    localparam int unsigned RING_DEPTH_DEF = 64;
    localparam int unsigned TOTAL_W        = 40;
    localparam int unsigned PROD_W         = 50;
    localparam int unsigned MS_PER_S       = 1000;

    localparam logic [19:0] WINDOW_RESET = 20'd15000;
    localparam logic [15:0] IDLE_RESET   = 16'd1000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_IDLE   = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [31:0]        timestamp_ms;
        logic signed [31:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] average_rate;
        logic               rate_saturated;
        logic signed [15:0] last_whole_value;
        logic               ring_overflow;
    } out_item_t;

    typedef struct packed {
        logic [19:0] window_ms;
        logic [15:0] idle_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] elapsed;
        logic [31:0] stamp;
    } entry_t;

    // Integer part of a Q16.16 value, truncated toward zero.
    function automatic logic [15:0] whole_part(input logic [31:0] v);
        logic [31:0] m;
        m = 32'd0 - v;
        if (v[31]) begin
            return 16'd0 - m[31:16];
        end
        return v[31:16];
    endfunction

endpackage

/* sv/sliding_window_rate_meter.sv */
// Top level of the sliding-window rate meter: front end, queue, engine, output register.
//
//   channel   direction  handshake                  payload
//   s_        in         s_valid / s_ready          s_data  (swrm_pkg::in_item_t)
//   m_        out        m_valid / m_ready          m_data  (swrm_pkg::out_item_t)
//   apb       in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Flow: a query that inserts nothing goes straight to the output state; a sample
// passes through insertion, eviction of each stale entry and, when the elapsed
// total is nonzero, the serial divider (one quotient bit per cycle).
// Reset: aresetn is synchronous and active low; the ring needs no clearing
// pass since an entry is only read after it is written.
// Stalls: a two-entry queue decouples the input from the engine, and the
// output register lets the engine finish while a result waits on m_ready.
`timescale 1ns / 1ps
module sliding_window_rate_meter #(
    parameter int unsigned RING_DEPTH = swrm_pkg::RING_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swrm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output swrm_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    swrm_pkg::cfg_t      cfg_reg;
    swrm_pkg::in_item_t  q_data;
    swrm_pkg::out_item_t res;
    swrm_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;
    logic                q_valid;
    logic                q_ready;
    logic                res_valid;
    logic                res_ready;
    logic                cfg_write;

    // Configuration port: no wait states, register picked by address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == swrm_pkg::REG_IDLE) ?
                       {16'd0, cfg_reg.idle_limit_ms} : {12'd0, cfg_reg.window_ms};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_ms     <= swrm_pkg::WINDOW_RESET;
            cfg_reg.idle_limit_ms <= swrm_pkg::IDLE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == swrm_pkg::REG_WINDOW) begin
                cfg_reg.window_ms <= pwdata[19:0];
            end else begin
                cfg_reg.idle_limit_ms <= pwdata[15:0];
            end
        end
    end

    // Front: buffer incoming transactions so the engine can stall on its own.
    swrm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (s_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // Back: ring maintenance, eviction and average.
    swrm_engine #(
        .RING_DEPTH (RING_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load when empty or when the current result drains.
    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end
endmodule

/* sv/swrm_queue.sv */
// Two-entry transaction queue between the front and back of the rate meter.
`timescale 1ns / 1ps
module swrm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  swrm_pkg::in_item_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output swrm_pkg::in_item_t  pop_data
);
    swrm_pkg::in_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end
endmodule

/* sv/swrm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module swrm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [swrm_pkg::PROD_W-1:0]    dividend,
    input  logic [swrm_pkg::TOTAL_W-1:0]   divisor,
    output logic                           done,
    output logic [swrm_pkg::PROD_W-1:0]    quotient
);
    localparam int unsigned NW = swrm_pkg::PROD_W;
    localparam int unsigned DW = swrm_pkg::TOTAL_W;
    localparam int unsigned CNT_W = $clog2(NW);

    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign fits     = (trial >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? DW'(trial - {1'b0, dsr_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

/* sv/swrm_engine.sv */
// Back end: ring update, window eviction and average computation.
`timescale 1ns / 1ps
module swrm_engine #(
    parameter int unsigned RING_DEPTH = swrm_pkg::RING_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  swrm_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  swrm_pkg::in_item_t  cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output swrm_pkg::out_item_t res
);
    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam int unsigned TW = swrm_pkg::TOTAL_W;
    localparam int unsigned PW = swrm_pkg::PROD_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INS    = 4'd1;
    localparam logic [3:0] ST_FULL   = 4'd2;
    localparam logic [3:0] ST_WRITE  = 4'd3;
    localparam logic [3:0] ST_EVSCAN = 4'd4;
    localparam logic [3:0] ST_EVCHK  = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_DIVGO  = 4'd7;
    localparam logic [3:0] ST_DIVWT  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    swrm_pkg::entry_t ring_mem [RING_DEPTH];
    swrm_pkg::entry_t rd_data_reg;

    logic [3:0]    state_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [TW-1:0] vtot_reg;
    logic [TW-1:0] etot_reg;
    logic [31:0]   prev_reg;
    logic [31:0]   avg_reg;
    logic          clamp_reg;
    logic [31:0]   latest_reg;
    logic          ovf_reg;
    logic [31:0]   now_reg;
    logic [31:0]   val_reg;
    logic [31:0]   el_reg;
    logic          neg_reg;
    logic [PW-1:0] prod_reg;

    logic [CW:0]   old_sum;
    logic [AW-1:0] oldest_idx;
    logic [31:0]   delta;
    logic          want_insert;
    logic [31:0]   win_start;
    logic [31:0]   age_diff;
    logic [TW-1:0] mag;
    logic          div_start;
    logic          div_done;
    logic [PW-1:0] div_quo;
    logic          sat_pos;
    logic          sat_neg;

    // Oldest slot: head minus fill, wrapped into the ring.
    assign old_sum    = (CW+1)'(head_reg) + (CW+1)'(RING_DEPTH) - (CW+1)'(count_reg);
    assign oldest_idx = (old_sum >= (CW+1)'(RING_DEPTH)) ?
                        AW'(old_sum - (CW+1)'(RING_DEPTH)) : AW'(old_sum);

    assign delta       = cmd.timestamp_ms - prev_reg;
    assign want_insert = (cmd.operation == swrm_pkg::OP_SAMPLE) ||
                         (!delta[31] && (delta > {16'd0, cfg.idle_limit_ms}));
    assign win_start   = now_reg - {12'd0, cfg.window_ms};
    assign age_diff    = rd_data_reg.stamp - win_start;
    assign mag         = vtot_reg[TW-1] ? (TW'(0) - vtot_reg) : vtot_reg;

    assign sat_pos = |div_quo[PW-1:31];
    assign sat_neg = (|div_quo[PW-1:32]) || (div_quo[31] && (|div_quo[30:0]));

    assign cmd_ready = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_DIVGO);
    assign res_valid = (state_reg == ST_OUT);

    assign res.average_rate     = avg_reg;
    assign res.rate_saturated   = clamp_reg;
    assign res.last_whole_value = swrm_pkg::whole_part(latest_reg);
    assign res.ring_overflow    = ovf_reg;

    swrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (etot_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            ring_mem[head_reg] <= '{value: val_reg, elapsed: el_reg, stamp: now_reg};
        end
        rd_data_reg <= ring_mem[oldest_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            vtot_reg   <= '0;
            etot_reg   <= '0;
            prev_reg   <= '0;
            avg_reg    <= '0;
            clamp_reg  <= 1'b0;
            latest_reg <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        now_reg <= cmd.timestamp_ms;
                        val_reg <= (cmd.operation == swrm_pkg::OP_SAMPLE) ?
                                   cmd.sample_value : 32'd0;
                        el_reg  <= delta[31] ? 32'd0 : delta;
                        if (want_insert) begin
                            latest_reg <= (cmd.operation == swrm_pkg::OP_SAMPLE) ?
                                          cmd.sample_value : 32'd0;
                            prev_reg   <= cmd.timestamp_ms;
                            state_reg  <= ST_INS;
                        end else begin
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_INS: begin
                    ovf_reg   <= (count_reg == CW'(RING_DEPTH));
                    state_reg <= (count_reg == CW'(RING_DEPTH)) ? ST_FULL : ST_WRITE;
                end
                ST_FULL: begin
                    vtot_reg  <= vtot_reg - {{(TW-32){rd_data_reg.value[31]}},
                                             rd_data_reg.value};
                    etot_reg  <= etot_reg - TW'(rd_data_reg.elapsed);
                    count_reg <= count_reg - 1'b1;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    head_reg  <= (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_reg <= count_reg + 1'b1;
                    vtot_reg  <= vtot_reg + {{(TW-32){val_reg[31]}}, val_reg};
                    etot_reg  <= etot_reg + TW'(el_reg);
                    state_reg <= ST_EVSCAN;
                end
                ST_EVSCAN: begin
                    state_reg <= (count_reg == '0) ? ST_MUL : ST_EVCHK;
                end
                ST_EVCHK: begin
                    if ((age_diff != 32'd0) && !age_diff[31]) begin
                        state_reg <= ST_MUL;
                    end else begin
                        vtot_reg  <= vtot_reg - {{(TW-32){rd_data_reg.value[31]}},
                                                 rd_data_reg.value};
                        etot_reg  <= etot_reg - TW'(rd_data_reg.elapsed);
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ST_EVSCAN;
                    end
                end
                ST_MUL: begin
                    if (etot_reg == '0) begin
                        avg_reg   <= '0;
                        clamp_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        neg_reg   <= vtot_reg[TW-1];
                        prod_reg  <= PW'(mag) * PW'(swrm_pkg::MS_PER_S);
                        state_reg <= ST_DIVGO;
                    end
                end
                ST_DIVGO: begin
                    state_reg <= ST_DIVWT;
                end
                ST_DIVWT: begin
                    if (div_done) begin
                        if (!neg_reg) begin
                            clamp_reg <= sat_pos;
                            avg_reg   <= sat_pos ? 32'h7FFF_FFFF : div_quo[31:0];
                        end else begin
                            clamp_reg <= sat_neg;
                            avg_reg   <= sat_neg ? 32'h8000_0000 : 32'd0 - div_quo[31:0];
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(RING_DEPTH))
        else $error("ring fill exceeds depth");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVGO) |-> (etot_reg != '0))
        else $error("division started with zero elapsed total");

    a_pop_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && cmd_ready) |=> (state_reg == ST_INS || state_reg == ST_OUT))
        else $error("accepted command took no path");

    a_res_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> (state_reg == ST_IDLE))
        else $error("engine did not return to idle after result");
endmodule

/* bench/tb_sliding_window_rate_meter.sv */
// Self-checking testbench of the sliding-window rate meter.
`timescale 1ns / 1ps
module tb_sliding_window_rate_meter;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned MAX_CYCLES = 1000000;
    localparam int unsigned HOLD_LEN   = 600;
    localparam int unsigned SETTLE     = 200;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    swrm_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    swrm_pkg::out_item_t m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    sliding_window_rate_meter #(.RING_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 aclk = ~aclk;

    // Stimulus and scoreboard storage.
    swrm_pkg::in_item_t  pending_items[$];
    swrm_pkg::out_item_t expected_results[$];
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_ask = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // Mirror of the block state: ring, running totals and registers.
    logic [31:0] ring_val[DEPTH];
    logic [31:0] ring_elapsed[DEPTH];
    logic [31:0] ring_time[DEPTH];
    logic [5:0]  ring_head = '0;
    logic [6:0]  fill_count = '0;
    logic [39:0] value_sum = '0;
    logic [39:0] elapsed_sum = '0;
    logic [31:0] prev_stamp = '0;
    logic [31:0] rate_now = '0;
    logic        rate_clamped = 1'b0;
    logic [31:0] latest_sample = '0;
    logic [19:0] window_cfg = swrm_pkg::WINDOW_RESET;
    logic [15:0] idle_cfg = swrm_pkg::IDLE_RESET;

    function automatic logic [5:0] oldest_slot();
        return ring_head - fill_count[5:0];
    endfunction

    // Remove the oldest entry from the totals.
    function automatic void drop_oldest();
        logic [5:0] idx;
        idx = oldest_slot();
        value_sum   = value_sum - {{8{ring_val[idx][31]}}, ring_val[idx]};
        elapsed_sum = elapsed_sum - {8'd0, ring_elapsed[idx]};
        fill_count  = fill_count - 7'd1;
    endfunction

    // Value sum per second, truncated toward zero and clamped to 32 bits.
    function automatic void update_rate();
        logic        neg;
        logic [39:0] mag;
        logic [63:0] quot;
        rate_clamped = 1'b0;
        if (elapsed_sum == 0) begin
            rate_now = '0;
            return;
        end
        neg  = value_sum[39];
        mag  = neg ? (40'd0 - value_sum) : value_sum;
        quot = ({24'd0, mag} * 64'd1000) / {24'd0, elapsed_sum};
        if (!neg) begin
            if (quot > 64'h7FFF_FFFF) begin
                quot = 64'h7FFF_FFFF;
                rate_clamped = 1'b1;
            end
            rate_now = quot[31:0];
        end else begin
            if (quot > 64'h8000_0000) begin
                quot = 64'h8000_0000;
                rate_clamped = 1'b1;
            end
            rate_now = 32'd0 - quot[31:0];
        end
    endfunction

    // Store a sample, evict stale entries, refresh the rate; returns the overflow flag.
    function automatic logic record_sample(logic [31:0] now, logic [31:0] val);
        logic [31:0] d, el, cutoff, diff;
        logic        ovf;
        d   = now - prev_stamp;
        el  = d[31] ? 32'd0 : d;
        ovf = 1'b0;
        latest_sample = val;
        prev_stamp    = now;
        if (fill_count >= DEPTH) begin
            drop_oldest();
            ovf = 1'b1;
        end
        ring_val[ring_head]     = val;
        ring_elapsed[ring_head] = el;
        ring_time[ring_head]    = now;
        ring_head   = ring_head + 6'd1;
        fill_count  = fill_count + 7'd1;
        value_sum   = value_sum + {{8{val[31]}}, val};
        elapsed_sum = elapsed_sum + {8'd0, el};
        cutoff = now - {12'd0, window_cfg};
        while (fill_count > 0) begin
            diff = ring_time[oldest_slot()] - cutoff;
            if (diff != 0 && !diff[31]) break;
            drop_oldest();
        end
        update_rate();
        return ovf;
    endfunction

    function automatic swrm_pkg::out_item_t predict_meter(swrm_pkg::in_item_t item);
        swrm_pkg::out_item_t res;
        logic [31:0]         d, m;
        logic                ovf;
        ovf = 1'b0;
        if (item.operation == swrm_pkg::OP_SAMPLE) begin
            ovf = record_sample(item.timestamp_ms, item.sample_value);
        end else begin
            d = item.timestamp_ms - prev_stamp;
            if (!d[31] && d > {16'd0, idle_cfg}) ovf = record_sample(item.timestamp_ms, 32'd0);
        end
        m = 32'd0 - latest_sample;
        res.average_rate     = rate_now;
        res.rate_saturated   = rate_clamped;
        res.last_whole_value = latest_sample[31] ? (16'd0 - m[31:16]) : latest_sample[31:16];
        res.ring_overflow    = ovf;
        return res;
    endfunction

    // Sender: offer the next pending item, hold it until accepted, idle at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_results.push_back(predict_meter(s_data));
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compare every result transaction against the oldest prediction.
    always @(posedge aclk) begin
        swrm_pkg::out_item_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_data.average_rate !== exp_res.average_rate) begin
                    $error("average_rate expected %h actual %h",
                           exp_res.average_rate, m_data.average_rate);
                    errors++;
                end
                if (m_data.rate_saturated !== exp_res.rate_saturated) begin
                    $error("rate_saturated expected %b actual %b",
                           exp_res.rate_saturated, m_data.rate_saturated);
                    errors++;
                end
                if (m_data.last_whole_value !== exp_res.last_whole_value) begin
                    $error("last_whole_value expected %h actual %h",
                           exp_res.last_whole_value, m_data.last_whole_value);
                    errors++;
                end
                if (m_data.ring_overflow !== exp_res.ring_overflow) begin
                    $error("ring_overflow expected %b actual %b",
                           exp_res.ring_overflow, m_data.ring_overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Setup cycle then access cycle; the register takes the value at the access edge.
    task automatic apb_write(logic reg_idx, logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (reg_idx == swrm_pkg::REG_WINDOW) ? 3'd0 : 3'd4;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == swrm_pkg::REG_WINDOW) window_cfg = data[19:0];
        else idle_cfg = data[15:0];
    endtask

    // Block until every transaction is sent and answered, then let the engine drain.
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic add_item(logic op, logic [31:0] stamp, logic [31:0] val);
        swrm_pkg::in_item_t item;
        item.operation    = op;
        item.timestamp_ms = stamp;
        item.sample_value = val;
        pending_items.push_back(item);
    endtask

    // Mostly small forward time steps, some long gaps, some backward, some arbitrary.
    task automatic add_random(int unsigned count, inout logic [31:0] stamp);
        int unsigned r;
        logic        op;
        logic [31:0] val;
        for (int unsigned i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) stamp = stamp + $urandom_range(0, 300);
            else if (r < 90) stamp = stamp + $urandom_range(0, 70000);
            else if (r < 96) stamp = stamp - $urandom_range(0, 5000);
            else stamp = $urandom;
            op  = ($urandom_range(0, 99) < 25) ? swrm_pkg::OP_QUERY : swrm_pkg::OP_SAMPLE;
            val = ($urandom_range(0, 1) == 0) ? $urandom
                                              : 32'($signed($urandom_range(0, 8192)) - 4096) <<< 12;
            add_item(op, stamp, val);
        end
    endtask

    initial begin
        logic [31:0] stamp;
        int unsigned win_list[7]  = '{15000, 1, 600000, 0, 30000, 2000, 600000};
        int unsigned idle_list[7] = '{1000, 0, 65535, 300, 0, 5000, 1000};
        int unsigned cnt_list[7]  = '{130, 150, 200, 50, 200, 200, 200};
        stamp = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed opening: zero elapsed, field extremes, saturation both ways,
        // backward time, idle and non-idle queries, timestamp wrap.
        send_idle_pct = 34;
        recv_idle_pct = 72;
        add_item(swrm_pkg::OP_QUERY,  32'd0,          32'd0);
        add_item(swrm_pkg::OP_SAMPLE, 32'd0,          32'h7FFF_FFFF);
        add_item(swrm_pkg::OP_SAMPLE, 32'd1,          32'h7FFF_FFFF);
        add_item(swrm_pkg::OP_QUERY,  32'd2,          32'hFFFF_FFFF);
        add_item(swrm_pkg::OP_SAMPLE, 32'd3,          32'h8000_0000);
        add_item(swrm_pkg::OP_SAMPLE, 32'd4,          32'h8000_0000);
        add_item(swrm_pkg::OP_SAMPLE, 32'd5,          32'h8000_0000);
        add_item(swrm_pkg::OP_SAMPLE, 32'd2,          32'hFFFF_0001);
        add_item(swrm_pkg::OP_SAMPLE, 32'd100,        32'h0001_8000);
        add_item(swrm_pkg::OP_QUERY,  32'd500,        32'd0);
        add_item(swrm_pkg::OP_QUERY,  32'd5000,       32'd0);
        add_item(swrm_pkg::OP_SAMPLE, 32'd5001,       32'hFFFE_8000);
        add_item(swrm_pkg::OP_SAMPLE, 32'd40000,      32'h0000_FFFF);
        add_item(swrm_pkg::OP_QUERY,  32'd39000,      32'd0);
        add_item(swrm_pkg::OP_SAMPLE, 32'hFFFF_FF00,  32'h7FFF_0000);
        add_item(swrm_pkg::OP_SAMPLE, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        add_item(swrm_pkg::OP_SAMPLE, 32'd200,        32'h0000_0001);
        add_item(swrm_pkg::OP_QUERY,  32'h7FFF_0000,  32'd0);
        add_item(swrm_pkg::OP_QUERY,  32'h7FFF_0001,  32'd0);
        add_item(swrm_pkg::OP_SAMPLE, 32'h8000_0000,  32'h1234_5678);
        stamp = 32'h8000_0000;
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            apb_write(swrm_pkg::REG_WINDOW, win_list[p]);
            apb_write(swrm_pkg::REG_IDLE, idle_list[p]);
            if (p >= 3 && p <= 4) begin
                send_idle_pct = 72;
                recv_idle_pct = 34;
            end else if (p >= 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Starve the output so the input queue fills and back-pressures.
            if (p == 5) hold_ask++;
            add_random(cnt_list[p], stamp);
        end
        wait_drained();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
